>>> rtl/lzfbd_pkg.sv
// Package for the LZSS flag-byte decompressor: controller and parse-phase types,
// register indexes, reset values and token-format constants.
// It has no dependencies. The decompressor top level imports it.
package lzfbd_pkg;

   // Default depth of the history window in bytes.
   localparam int WINDOW_DEPTH_DEFAULT = 4096;

   // Configuration register indexes.
   localparam logic CSR_OUTPUT_SIZE = 1'b0;
   localparam logic CSR_HEADER_SKIP = 1'b1;

   // Configuration reset values.
   localparam logic [15:0] OUTPUT_SIZE_RESET = 16'd8000;
   localparam logic [7:0]  HEADER_SKIP_RESET = 8'd8;

   // Token format.
   localparam logic [4:0]  LENGTH_BIAS = 5'd3;
   localparam logic [3:0]  FLAG_RELOAD = 4'd8;
   localparam int          OFFSET_WIDTH = 13;

   // Controller states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COPY_RD,
      ST_EMIT
   } ctrl_state_type;

   // Parse phases of the compressed stream.
   typedef enum logic [1:0] {
      PH_HEADER,
      PH_TOKEN,
      PH_REFHI
   } phase_type;

endpackage

>>> rtl/lz77_flag_byte_decompressor_unit.sv
// LZSS flag-byte decompressor top level: parser, history window memory and
// output register. Depends on lzfbd_pkg for types, register indexes and constants.
//
// Takes one compressed byte per input word and returns the decoded bytes, one
// byte per output word. After reset the history window is swept to zero, one entry
// per cycle. The input is stalled during that sweep, but configuration writes are
// taken. A header byte, a flag byte or the low byte of a back-reference is accepted
// without an output. A literal is accepted and then emitted from the emit state. Each
// of the N copied bytes of a back-reference is first read from the window memory,
// which has a registered read port, and then emitted and written back. A stall on
// the output channel holds the emit state. One result word waits in the output
// register while the next input word is accepted.
module lz77_flag_byte_decompressor_unit
   import lzfbd_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Compressed byte input.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_stream_start,
   // Decoded byte output.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_image_done,
   // Configuration write port.
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(WINDOW_DEPTH);

   // History window memory.
   logic [7:0] window_mem [WINDOW_DEPTH];
   logic [7:0] rd_data_ff;

   // Controller and configuration registers.
   ctrl_state_type state_ff, state_in;
   logic [15:0]    output_size_ff;
   logic [7:0]     header_skip_ff;

   // Parser state.
   logic [15:0]    rem_ff, rem_in;
   logic [7:0]     flag_bits_ff, flag_bits_in;
   logic [3:0]     flag_pos_ff, flag_pos_in;
   phase_type      phase_ff, phase_in;
   logic [7:0]     off_lo_ff, off_lo_in;
   logic [7:0]     header_left_ff, header_left_in;
   logic [AW-1:0]  wp_ff, wp_in;
   logic [AW-1:0]  clr_ff;

   // Copy and literal working registers.
   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic [4:0]     count_ff, count_in;
   logic [7:0]     lit_ff, lit_in;
   logic           is_copy_ff, is_copy_in;

   // Output register.
   logic           rsp_valid_ff;
   logic [7:0]     rsp_byte_ff;
   logic           rsp_last_ff;
   logic           rsp_done_ff;

   // Strobes.
   logic           accept;
   logic           out_free;
   logic           emit_fire;
   logic           go_copy;
   logic           go_lit;
   logic           mem_we;
   logic           mem_re;
   logic [AW-1:0]  mem_waddr;
   logic [7:0]     mem_wdata;
   logic [AW-1:0]  src_addr;
   logic [7:0]     emit_byte;
   logic [15:0]    rem_dec;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign emit_byte = is_copy_ff ? rd_data_ff : lit_ff;
   assign rem_dec   = rem_ff - 16'd1;

   // The source address of a copy lies offset bytes behind the write pointer,
   // modulo the window depth.
   always_comb begin
      logic [AW:0] wp_ext;
      logic [AW:0] off_ext;
      logic [AW:0] diff;
      wp_ext  = {1'b0, wp_ff};
      off_ext = (AW+1)'(offset_ff);
      if (wp_ext >= off_ext) begin
         diff = wp_ext - off_ext;
      end else begin
         diff = wp_ext + DEPTH_EXT - off_ext;
      end
      src_addr = diff[AW-1:0];
   end

   // Parsing of an accepted byte. A stream start resets the parser first.
   always_comb begin
      logic [15:0] st_rem;
      phase_type   st_phase;
      logic [7:0]  st_hl;
      logic [3:0]  st_fpos;
      logic [7:0]  st_fbits;
      logic [7:0]  st_olo;
      logic [AW-1:0] st_wp;
      logic [4:0]  len;
      st_rem   = req_stream_start ? output_size_ff : rem_ff;
      st_phase = req_stream_start ? PH_HEADER : phase_ff;
      st_hl    = req_stream_start ? header_skip_ff : header_left_ff;
      st_fpos  = req_stream_start ? FLAG_RELOAD : flag_pos_ff;
      st_fbits = req_stream_start ? 8'd0 : flag_bits_ff;
      st_olo   = req_stream_start ? 8'd0 : off_lo_ff;
      st_wp    = req_stream_start ? '0 : wp_ff;
      len      = {1'b0, req_in_byte[7:4]} + LENGTH_BIAS;

      rem_in         = st_rem;
      phase_in       = st_phase;
      header_left_in = st_hl;
      flag_pos_in    = st_fpos;
      flag_bits_in   = st_fbits;
      off_lo_in      = st_olo;
      wp_in          = st_wp;
      offset_in      = offset_ff;
      count_in       = count_ff;
      lit_in         = lit_ff;
      is_copy_in     = is_copy_ff;
      go_copy        = 1'b0;
      go_lit         = 1'b0;

      if (st_rem != 16'd0) begin
         if (st_phase == PH_HEADER && st_hl != 8'd0) begin
            header_left_in = st_hl - 8'd1;
         end else begin
            case (st_phase)
               PH_REFHI: begin
                  // High byte of a back-reference: start the copy.
                  offset_in  = {1'b0, req_in_byte[3:0], st_olo} + OFFSET_WIDTH'(1);
                  count_in   = ({11'd0, len} > st_rem) ? st_rem[4:0] : len;
                  is_copy_in = 1'b1;
                  go_copy    = 1'b1;
                  phase_in   = PH_TOKEN;
                  flag_pos_in = st_fpos + 4'd1;
               end
               default: begin
                  // Header finished or waiting for a token.
                  phase_in = PH_TOKEN;
                  if (st_fpos >= FLAG_RELOAD) begin
                     flag_bits_in = req_in_byte;
                     flag_pos_in  = 4'd0;
                  end else if (st_fbits[st_fpos[2:0]]) begin
                     lit_in      = req_in_byte;
                     is_copy_in  = 1'b0;
                     go_lit      = 1'b1;
                     flag_pos_in = st_fpos + 4'd1;
                  end else begin
                     off_lo_in = req_in_byte;
                     phase_in  = PH_REFHI;
                  end
               end
            endcase
         end
      end
   end

   // Next state of the controller.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && go_copy) begin
               state_in = ST_COPY_RD;
            end else if (accept && go_lit) begin
               state_in = ST_EMIT;
            end
         end
         ST_COPY_RD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = (is_copy_ff && count_ff != 5'd1) ? ST_COPY_RD : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Controller outputs: memory strobes and the emit strobe.
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      emit_fire = 1'b0;
      mem_waddr = wp_ff;
      mem_wdata = emit_byte;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 8'd0;
         end
         ST_COPY_RD: begin
            mem_re = 1'b1;
         end
         ST_EMIT: begin
            emit_fire = out_free;
            mem_we    = out_free;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // History window memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= window_mem[src_addr];
      end
   end

   // Control and parser registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         output_size_ff <= OUTPUT_SIZE_RESET;
         header_skip_ff <= HEADER_SKIP_RESET;
         rem_ff         <= 16'd0;
         flag_bits_ff   <= 8'd0;
         flag_pos_ff    <= FLAG_RELOAD;
         phase_ff       <= PH_HEADER;
         off_lo_ff      <= 8'd0;
         header_left_ff <= 8'd0;
         wp_ff          <= '0;
         count_ff       <= 5'd0;
         is_copy_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         // Clearing sweep address.
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end

         // Configuration writes.
         if (csr_write_enable) begin
            case (csr_index)
               CSR_OUTPUT_SIZE: output_size_ff <= csr_write_data;
               CSR_HEADER_SKIP: header_skip_ff <= csr_write_data[7:0];
               default: output_size_ff <= output_size_ff;
            endcase
         end

         // Parser update on an accepted byte.
         if (accept) begin
            rem_ff         <= rem_in;
            flag_bits_ff   <= flag_bits_in;
            flag_pos_ff    <= flag_pos_in;
            phase_ff       <= phase_in;
            off_lo_ff      <= off_lo_in;
            header_left_ff <= header_left_in;
            wp_ff          <= wp_in;
            count_ff       <= count_in;
            is_copy_ff     <= is_copy_in;
         end

         // Emitting a byte advances the window and the remaining count.
         if (emit_fire) begin
            rem_ff   <= rem_dec;
            wp_ff    <= (wp_ff == LAST_ADDR) ? '0 : wp_ff + AW'(1);
            count_ff <= count_ff - 5'd1;
         end

         // Output register valid.
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         offset_ff <= offset_in;
         lit_ff    <= lit_in;
      end
      if (emit_fire) begin
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= !is_copy_ff || (count_ff == 5'd1);
         rsp_done_ff <= (rem_dec == 16'd0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_image_done = rsp_done_ff;

   // A byte is emitted only while bytes remain.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (rem_ff != 16'd0))
      else $error("emit with no bytes remaining");

   // A copy never starts or continues with an empty count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY_RD) |-> (count_ff != 5'd0 && is_copy_ff))
      else $error("copy read with empty count");

   // The byte that completes the image is always the last of its input word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_image_done) |-> rsp_run_last)
      else $error("image done without run last");

   // The emitted byte that empties the count is flagged as image done.
   assert property (@(posedge clock) disable iff (reset)
      (emit_fire && rem_ff == 16'd1) |=> (rsp_valid && rsp_image_done))
      else $error("image done flag missing");

   // The flag position never passes the reload mark.
   assert property (@(posedge clock) disable iff (reset)
      flag_pos_ff <= FLAG_RELOAD)
      else $error("flag position out of range");

endmodule
